@@ hw/rtl/wmc_pkg.sv @@
// wmc_pkg: shared types, constants and the byte classifier of the word match counter
// no dependencies
package wmc_pkg;

    localparam int MAX_WORD_CHARS_DEF = 16;
    localparam int COUNT_BITS_DEF     = 16;
    localparam int QUEUE_DEPTH        = 4;

    localparam int CHAR_BITS   = 8;
    localparam int OUT_BITS    = 16;
    localparam int WORD_BITS   = 64;
    localparam int LEN_BITS    = 5;
    localparam int POS_BITS    = 5;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WORD_LOW  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WORD_HIGH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WORD_LEN  = 2'd2;

    // input beat kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    localparam logic [LEN_BITS-1:0] WORD_LEN_RESET = 5'd1;

    typedef enum logic [1:0] {
        CLS_CHAR,
        CLS_DELIM,
        CLS_EOS
    } t_cls;

    typedef struct packed {
        t_cls                 cls;
        logic [CHAR_BITS-1:0] ch;
    } t_item;

    function automatic logic is_delim(input logic [CHAR_BITS-1:0] c);
        return (c >= 8'd9  && c <= 8'd13)  || (c >= 8'd32  && c <= 8'd47) ||
               (c >= 8'd58 && c <= 8'd64)  || (c >= 8'd91  && c <= 8'd96) ||
               (c >= 8'd123 && c <= 8'd126);
    endfunction

endpackage

@@ hw/rtl/wmc_if.sv @@
// wmc_if: valid/ready channel interfaces for the input bytes and the match count
// depends on wmc_pkg
interface wmc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [wmc_pkg::CHAR_BITS-1:0] char_byte;

    modport source (output valid, kind, char_byte, input ready);
    modport sink   (input valid, kind, char_byte, output ready);
endinterface

interface wmc_out_if;
    logic                         valid;
    logic                         ready;
    logic [wmc_pkg::OUT_BITS-1:0] match_count;

    modport source (output valid, match_count, input ready);
    modport sink   (input valid, match_count, output ready);
endinterface

@@ hw/rtl/word_match_counter.sv @@
// word_match_counter: whole-word occurrence counter over a byte stream, top level
// depends on wmc_pkg, wmc_if, wmc_front, wmc_fifo and wmc_back
//
//  channel  dir  handshake          payload
//  i_in     in   valid/ready        kind, char_byte
//  o_out    out  valid/ready        match_count (one beat per end of stream)
//  i_cfg_*  in   write enable only  index 0..2, 64-bit data
//
// one byte per cycle while the output does not stall; a byte reaches the counter through
// the classify register, then the queue, and a count is registered in the result register
// on the edge that pops its end of stream.
// reset clears the token state, counter and word registers (length 1).
// a stalled output holds only the end-of-stream beat; bytes keep flowing until the queue
// and the classify register fill.
module word_match_counter #(
    parameter int MAX_WORD_CHARS = wmc_pkg::MAX_WORD_CHARS_DEF,
    parameter int COUNT_BITS     = wmc_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wmc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [wmc_pkg::WORD_BITS-1:0]    i_cfg_data,
    wmc_in_if.sink                           i_in,
    wmc_out_if.source                        o_out
);

    logic           front_valid;
    wmc_pkg::t_item front_item;
    logic           front_ready;
    logic           back_valid;
    wmc_pkg::t_item back_item;
    logic           back_ready;

    wmc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_ready (front_ready)
    );

    wmc_fifo #(
        .DEPTH (wmc_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_item  (front_item),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_item   (back_item),
        .i_pop_ready  (back_ready)
    );

    wmc_back #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (back_valid),
        .i_item     (back_item),
        .o_ready    (back_ready),
        .o_out      (o_out)
    );

endmodule

@@ hw/rtl/wmc_front.sv @@
// wmc_front: accepts input beats, classifies each byte and holds it in one register stage
// depends on wmc_pkg and wmc_if
module wmc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    wmc_in_if.sink         i_in,
    output logic           o_valid,
    output wmc_pkg::t_item o_item,
    input  logic           i_ready
);

    logic           r_valid;
    wmc_pkg::t_item r_item;
    wmc_pkg::t_item n_item;
    logic           accept;

    assign i_in.ready = !r_valid || i_ready;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_item.ch = i_in.char_byte;
        if (i_in.kind == wmc_pkg::KIND_EOS) begin
            n_item.cls = wmc_pkg::CLS_EOS;
        end else if (wmc_pkg::is_delim(i_in.char_byte)) begin
            n_item.cls = wmc_pkg::CLS_DELIM;
        end else begin
            n_item.cls = wmc_pkg::CLS_CHAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ hw/rtl/wmc_fifo.sv @@
// wmc_fifo: short queue of classified items between the front and back parts
// depends on wmc_pkg
module wmc_fifo #(
    parameter int DEPTH = wmc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  wmc_pkg::t_item i_push_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output wmc_pkg::t_item o_pop_item,
    input  logic           i_pop_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wmc_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           push;
    logic           pop;

    assign o_push_ready = r_count != CW'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");

endmodule

@@ hw/rtl/wmc_back.sv @@
// wmc_back: token tracking, word compare, match counter and the result register
// depends on wmc_pkg and wmc_if
module wmc_back #(
    parameter int MAX_WORD_CHARS = wmc_pkg::MAX_WORD_CHARS_DEF,
    parameter int COUNT_BITS     = wmc_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wmc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [wmc_pkg::WORD_BITS-1:0]       i_cfg_data,
    input  logic                                i_valid,
    input  wmc_pkg::t_item                      i_item,
    output logic                                o_ready,
    wmc_out_if.source                           o_out
);

    logic [wmc_pkg::WORD_BITS-1:0]  r_word_lo;
    logic [wmc_pkg::WORD_BITS-1:0]  r_word_hi;
    logic [wmc_pkg::LEN_BITS-1:0]   r_word_len;

    logic [wmc_pkg::POS_BITS-1:0]   r_pos, n_pos;
    logic                           r_mismatch, n_mismatch;
    logic [COUNT_BITS-1:0]          r_cnt, n_cnt;
    logic                           r_out_valid;
    logic [wmc_pkg::OUT_BITS-1:0]   r_out_count, n_out_count;

    logic [2*wmc_pkg::WORD_BITS-1:0] word;
    logic [wmc_pkg::CHAR_BITS-1:0]   word_ch;
    logic                            len_ok;
    logic                            hit;
    logic [COUNT_BITS-1:0]           cnt_fin;
    logic [31:0]                     cnt_wide;
    logic                            take;
    logic                            is_eos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_lo  <= '0;
            r_word_hi  <= '0;
            r_word_len <= wmc_pkg::WORD_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wmc_pkg::REG_WORD_LOW:  r_word_lo  <= i_cfg_data;
                wmc_pkg::REG_WORD_HIGH: r_word_hi  <= i_cfg_data;
                wmc_pkg::REG_WORD_LEN:  r_word_len <= i_cfg_data[wmc_pkg::LEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign is_eos  = i_item.cls == wmc_pkg::CLS_EOS;
    // an end-of-stream item waits for the result register to be free
    assign o_ready = !is_eos || !r_out_valid || o_out.ready;
    assign take    = i_valid && o_ready;

    assign word    = {r_word_hi, r_word_lo};
    assign word_ch = word[{r_pos[3:0], 3'b000} +: wmc_pkg::CHAR_BITS];
    assign len_ok  = r_word_len != '0 &&
                     r_word_len <= wmc_pkg::LEN_BITS'(MAX_WORD_CHARS);
    // the token in flight is a whole match of the word and the counter is not yet full
    assign hit     = len_ok && r_pos == r_word_len && !r_mismatch && !(&r_cnt);
    assign cnt_fin = hit ? r_cnt + 1'b1 : r_cnt;
    assign cnt_wide = 32'(cnt_fin);

    always_comb begin
        n_pos       = r_pos;
        n_mismatch  = r_mismatch;
        n_cnt       = r_cnt;
        n_out_count = (|cnt_wide[31:wmc_pkg::OUT_BITS]) ? '1
                                                        : cnt_wide[wmc_pkg::OUT_BITS-1:0];
        unique case (i_item.cls)
            wmc_pkg::CLS_EOS: begin
                n_pos      = '0;
                n_mismatch = 1'b0;
                n_cnt      = '0;
            end
            wmc_pkg::CLS_DELIM: begin
                n_pos      = '0;
                n_mismatch = 1'b0;
                n_cnt      = cnt_fin;
            end
            wmc_pkg::CLS_CHAR: begin
                if (r_pos < r_word_len &&
                    r_pos < wmc_pkg::POS_BITS'(MAX_WORD_CHARS)) begin
                    if (word_ch != i_item.ch) begin
                        n_mismatch = 1'b1;
                    end
                end else begin
                    n_mismatch = 1'b1;
                end
                if (!(&r_pos)) begin
                    n_pos = r_pos + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_mismatch  <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_pos      <= n_pos;
                r_mismatch <= n_mismatch;
                r_cnt      <= n_cnt;
            end
            if (take && is_eos) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && is_eos) begin
            r_out_count <= n_out_count;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.match_count = r_out_count;

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && is_eos) |=> (r_pos == '0 && !r_mismatch && r_cnt == '0 && r_out_valid))
        else $error("end of stream did not clear the token state");

    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(take && is_eos) |=> r_cnt >= $past(r_cnt))
        else $error("match counter went down without end of stream");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !(take && is_eos))
        else $error("result overwritten before it was taken");

endmodule

@@ tb/sv/wmc_checker.sv @@
`timescale 1ns / 100ps
// wmc_checker: watches the byte and count channels and the register port of the word
// match counter, predicts every count and compares it with the beat that comes out
// depends on wmc_pkg and wmc_if
module wmc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wmc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [wmc_pkg::WORD_BITS-1:0]    i_cfg_data,
    wmc_in_if                                i_in_mon,
    wmc_out_if                               i_out_mon,
    output int                               o_fail_count,
    output int                               o_counts_pending,
    output int                               o_counts_checked
);
    import wmc_pkg::*;

    localparam int MAX_CHARS = MAX_WORD_CHARS_DEF;
    localparam logic [COUNT_BITS_DEF-1:0] TALLY_TOP = '1;

    logic [WORD_BITS-1:0]      word_lo;
    logic [WORD_BITS-1:0]      word_hi;
    logic [LEN_BITS-1:0]       word_len;
    logic [POS_BITS-1:0]       tok_pos;
    logic                      tok_bad;
    logic [COUNT_BITS_DEF-1:0] tally;
    logic [OUT_BITS-1:0]       count_q[$];

    int fails   = 0;
    int checked = 0;
    int pending = 0;

    assign o_fail_count     = fails;
    assign o_counts_pending = pending;
    assign o_counts_checked = checked;

    function automatic logic is_separator(input logic [CHAR_BITS-1:0] c);
        return (c >= 8'd9   && c <= 8'd13) || (c >= 8'd32 && c <= 8'd47) ||
               (c >= 8'd58  && c <= 8'd64) || (c >= 8'd91 && c <= 8'd96) ||
               (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic [CHAR_BITS-1:0] word_char_at(input logic [3:0] k);
        return k[3] ? word_hi[8*k[2:0] +: 8] : word_lo[8*k[2:0] +: 8];
    endfunction

    // a token only counts when it is exactly the word, the word length is legal and the tally is not full
    function automatic void close_token();
        if (word_len >= 1 && word_len <= MAX_CHARS && tok_pos == word_len && !tok_bad &&
            tally != TALLY_TOP)
            tally++;
        tok_pos = '0;
        tok_bad = 1'b0;
    endfunction

    function automatic void absorb_char(input logic [CHAR_BITS-1:0] c);
        if (tok_pos < word_len && tok_pos < MAX_CHARS) begin
            if (word_char_at(tok_pos[3:0]) != c)
                tok_bad = 1'b1;
        end else begin
            tok_bad = 1'b1;
        end
        if (tok_pos != '1)
            tok_pos++;
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_BITS-1:0] want;
        if (!i_rst_n) begin
            word_lo  = '0;
            word_hi  = '0;
            word_len = WORD_LEN_RESET;
            tok_pos  = '0;
            tok_bad  = 1'b0;
            tally    = '0;
            count_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WORD_LOW:  word_lo = i_cfg_data;
                    REG_WORD_HIGH: word_hi = i_cfg_data;
                    REG_WORD_LEN:  word_len = i_cfg_data[LEN_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.kind == KIND_EOS) begin
                    close_token();
                    count_q.push_back(tally);
                    tally = '0;
                end else if (is_separator(i_in_mon.char_byte)) begin
                    close_token();
                end else begin
                    absorb_char(i_in_mon.char_byte);
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (count_q.size() == 0) begin
                    fails <= fails + 1;
                    $display("%0t: unexpected count beat, expected none, got %0d",
                             $time, i_out_mon.match_count);
                end else begin
                    want = count_q.pop_front();
                    checked <= checked + 1;
                    if (want !== i_out_mon.match_count) begin
                        fails <= fails + 1;
                        $display("%0t: match count mismatch, expected %0d, got %0d",
                                 $time, want, i_out_mon.match_count);
                    end
                end
            end
        end
        pending <= count_q.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// testbench: drives byte streams and register writes into word_match_counter under
// varying back-pressure, with wmc_checker alongside doing prediction and comparison
// depends on wmc_pkg, wmc_if, word_match_counter and wmc_checker
module testbench;
    import wmc_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 720;
    localparam int NUM_PHASES     = 12;

    logic                    i_clk    = 1'b0;
    logic                    i_rst_n  = 1'b0;
    logic                    cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx  = '0;
    logic [WORD_BITS-1:0]    cfg_data = '0;

    wmc_in_if  byte_ch ();
    wmc_out_if count_ch ();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fail_count;
    int counts_pending;
    int counts_checked;
    int bytes_sent    = 0;
    int streams_sent  = 0;
    int quiet_cycles  = 0;
    int word_len_cfg  = 1;

    logic [CHAR_BITS-1:0] word_chars[16];
    logic [CHAR_BITS-1:0] text_q[$];

    word_match_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (byte_ch),
        .o_out      (count_ch)
    );

    wmc_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_mon         (byte_ch),
        .i_out_mon        (count_ch),
        .o_fail_count     (fail_count),
        .o_counts_pending (counts_pending),
        .o_counts_checked (counts_checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial count_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        count_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // counts cycles in which nothing moves at all
    always @(posedge i_clk) begin
        if ((byte_ch.valid && byte_ch.ready) || (count_ch.valid && count_ch.ready) ||
            cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [CHAR_BITS-1:0] word_byte();
        case ($urandom_range(5))
            0:       return CHAR_BITS'($urandom_range(8));
            1:       return CHAR_BITS'($urandom_range(31, 14));
            2:       return CHAR_BITS'($urandom_range(57, 48));
            3:       return CHAR_BITS'($urandom_range(90, 65));
            4:       return CHAR_BITS'($urandom_range(122, 97));
            default: return CHAR_BITS'($urandom_range(255, 127));
        endcase
    endfunction

    function automatic logic [CHAR_BITS-1:0] separator_byte();
        case ($urandom_range(4))
            0:       return CHAR_BITS'($urandom_range(13, 9));
            1:       return CHAR_BITS'($urandom_range(47, 32));
            2:       return CHAR_BITS'($urandom_range(64, 58));
            3:       return CHAR_BITS'($urandom_range(96, 91));
            default: return CHAR_BITS'($urandom_range(126, 123));
        endcase
    endfunction

    function automatic void fill_word_chars(input bit with_separator, input int len);
        foreach (word_chars[k])
            word_chars[k] = word_byte();
        // a word holding a separator can never be matched
        if (with_separator)
            word_chars[$urandom_range((len > 16 ? 16 : len) - 1)] = separator_byte();
    endfunction

    function automatic void queue_separators();
        repeat ($urandom_range(3, 1))
            text_q.push_back(separator_byte());
    endfunction

    // mostly the exact word, else a prefix, an overlong copy, one altered char or junk
    function automatic void queue_token();
        int                   variant;
        int                   n;
        int                   slot;
        logic [CHAR_BITS-1:0] ch;
        variant = $urandom_range(9);
        n = word_len_cfg;
        if (variant == 5 && n > 1)
            n--;
        else if (variant == 6)
            n++;
        else if (variant == 8)
            n = $urandom_range(20, 1);
        for (int k = 0; k < n; k++) begin
            if (variant == 8 || k >= 16 || k >= word_len_cfg)
                ch = word_byte();
            else
                ch = word_chars[k];
            text_q.push_back(ch);
        end
        if (variant == 7 && n > 0) begin
            slot = text_q.size() - n + $urandom_range(n - 1);
            do ch = word_byte(); while (ch == text_q[slot]);
            text_q[slot] = ch;
        end
    endfunction

    task automatic send_item(input logic kind, input logic [CHAR_BITS-1:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.kind      <= kind;
        byte_ch.char_byte <= ch;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        if (kind == KIND_EOS)
            streams_sent++;
        else
            bytes_sent++;
    endtask

    task automatic flush_text();
        foreach (text_q[k])
            send_item(KIND_CHAR, text_q[k]);
        text_q.delete();
    endtask

    // hold the sender until every count is out, then let the pipeline empty
    task automatic drain_counts();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (counts_pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
    endtask

    task automatic write_word(input int len);
        logic [WORD_BITS-1:0] lo;
        logic [WORD_BITS-1:0] hi;
        logic [WORD_BITS-1:0] len_data;
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = word_chars[k];
            hi[8*k +: 8] = word_chars[k+8];
        end
        len_data = {$urandom, $urandom};
        len_data[LEN_BITS-1:0] = len[LEN_BITS-1:0];
        word_len_cfg = len;
        drain_counts();
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_WORD_LOW;
        cfg_data <= lo;
        @(posedge i_clk);
        cfg_idx  <= REG_WORD_HIGH;
        cfg_data <= hi;
        @(posedge i_clk);
        cfg_idx  <= REG_WORD_LEN;
        cfg_data <= len_data;
        @(posedge i_clk);
        // the unused index must leave every register alone
        cfg_idx  <= REG_SPARE;
        cfg_data <= {$urandom, $urandom};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_random_stream();
        int ntok;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(30, 1))
                text_q.push_back(CHAR_BITS'($urandom_range(255)));
        end else begin
            if ($urandom_range(3) == 0)
                queue_separators();
            ntok = $urandom_range(4, 1);
            for (int t = 0; t < ntok; t++) begin
                queue_token();
                if (t < ntok - 1 || $urandom_range(1))
                    queue_separators();
            end
        end
        flush_text();
        // now and then the stream runs on into the next one
        if ($urandom_range(9) != 0)
            send_item(KIND_EOS, CHAR_BITS'($urandom_range(255)));
    endtask

    initial begin
        int len;
        int phase_end;
        byte_ch.valid     = 1'b0;
        byte_ch.kind      = KIND_CHAR;
        byte_ch.char_byte = '0;
        repeat (11)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stream, then the reset word, a single zero byte
        send_item(KIND_EOS, 8'hFF);
        text_q = '{8'h20, 8'h00, 8'h09, 8'h00, 8'h00, 8'h7E, 8'h00};
        flush_text();
        send_item(KIND_EOS, 8'h00);

        // longest word, matched with no trailing separator
        foreach (word_chars[k])
            word_chars[k] = CHAR_BITS'(8'h61 + k);
        write_word(16);
        foreach (word_chars[k])
            text_q.push_back(word_chars[k]);
        flush_text();
        send_item(KIND_EOS, 8'h00);

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 82; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 82; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            case (p)
                0:       len = 1;
                1:       len = 16;
                2:       len = 0;
                3:       len = $urandom_range(31, 17);
                4:       len = $urandom_range(8, 1);
                default: len = $urandom_range(5, 1);
            endcase
            fill_word_chars(p == 4, len);
            if (p == 6)
                foreach (word_chars[k]) word_chars[k] = 8'hFF;
            if (p == 7)
                foreach (word_chars[k]) word_chars[k] = 8'h00;
            write_word(len);
            phase_end = bytes_sent + streams_sent + RANDOM_ITEMS / NUM_PHASES;
            while (bytes_sent + streams_sent < phase_end)
                send_random_stream();
        end

        drain_counts();
        $display("covered %0d bytes in %0d streams over %0d word settings plus directed cases,",
                 bytes_sent, streams_sent, NUM_PHASES);
        $display("four back-pressure mixes and held-off senders; %0d counts compared",
                 counts_checked);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
